// ----- rtl/wlpt_pkg.sv -----
// Shared types and constants for the worst-latency path tracker.
package wlpt_pkg;

  // Command codes
  localparam logic [2:0] CMD_START  = 3'd0;
  localparam logic [2:0] CMD_CHECK  = 3'd1;
  localparam logic [2:0] CMD_END    = 3'd2;
  localparam logic [2:0] CMD_CAUSE  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;

  // Sync states
  localparam logic [1:0] SYNC_WAIT_START = 2'd0;
  localparam logic [1:0] SYNC_WAIT_END   = 2'd1;
  localparam logic [1:0] SYNC_EITHER     = 2'd2;

  // Register indexes
  localparam logic CFG_LOG_EN  = 1'b0;
  localparam logic CFG_DOWN    = 1'b1;

  localparam logic [15:0] MASK_SELECTOR = 16'hFF9C;

  // 163 input bits padded to whole bytes; 288 result bits are whole bytes
  localparam int IN_W  = 168;
  localparam int OUT_W = 288;

  // Unpacked input beat
  typedef struct packed {
    logic [15:0] cause_from;
    logic [15:0] cause;
    logic [15:0] process_id;
    logic [15:0] site_line;
    logic [31:0] site_file;
    logic [31:0] site_address;
    logic [31:0] timestamp;
    logic [2:0]  command;
  } in_item_t;

  // One table entry
  typedef struct packed {
    logic [31:0] latency;
    logic [15:0] cause;
    logic [15:0] mask;
    logic [31:0] begin_address;
    logic [31:0] begin_file;
    logic [15:0] begin_line;
    logic [15:0] begin_process;
    logic [31:0] finish_address;
    logic [31:0] finish_file;
    logic [15:0] finish_line;
    logic [15:0] finish_process;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic scan_clr;   // reset scan registers
    logic scan_step;  // compare current entry
    logic scan_hunt;  // stop the scan at a matching entry
    logic log_done;   // apply log decision
    logic read_done;  // produce read result and clear entry
    logic do_open;
    logic do_cause;
    logic do_clear;
    logic cnt_unmatched;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic       above_floor;
    logic       match_hit;
    logic       scan_last;
  } dp_stat_t;

endpackage

// ----- rtl/worst_latency_path_tracker.sv -----
// Top level of the worst-latency path tracker.
// Channel | Direction | Beat contents
// in_     | input     | command, timestamp, site, process, cause, cause_from
// out_    | output    | read_worst result: entry fields and measured total
// cfg_    | input     | register write: logging_enable, clock_counts_down
// Each command is decoded first. A logged interval then scans the table, one
// table entry compared per cycle, stopping at a match, and is then written;
// read_worst walks the whole table. Reset is synchronous active low and
// clears the table through per-entry valid bits at once. A result waits in
// the output register; a further read waits until it is taken.
module worst_latency_path_tracker import wlpt_pkg::*; #(
  parameter int TABLE_ENTRIES = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command, timestamp, site_address, site_file, site_line, process_id,
  // cause, cause_from
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // worst_latency, worst_cause, worst_mask, begin_address, begin_file,
  // begin_line, begin_process, finish_address, finish_file, finish_line,
  // finish_process, measured_total
  output logic [287:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic         cfg_wdata
);

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [1:0] sync_state, sync_nxt;
  logic       sync_wr, idle, out_set, in_fire, out_fire;
  logic       log_en_r, down_r, ov_r;

  assign in_tready  = idle;
  assign in_fire    = in_tvalid && idle;
  assign out_fire   = out_tvalid && out_tready;
  assign out_tvalid = ov_r;

  // Configuration registers and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_en_r <= 1'b0; down_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_LOG_EN) log_en_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_DOWN)   down_r   <= cfg_wdata;
      if (out_set) ov_r <= 1'b1;
      else if (out_fire) ov_r <= 1'b0;
    end
  end

  wlpt_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_busy(ov_r), .out_fire, .log_en(log_en_r),
    .stat, .sync_state, .cmd, .sync_nxt, .sync_wr, .idle, .out_set
  );

  wlpt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk, .rst_n, .in_bits(in_tdata), .cfg_down(down_r), .cmd, .stat,
    .out_bits(out_tdata), .sync_state, .sync_nxt, .sync_wr
  );

endmodule

// ----- rtl/wlpt_datapath.sv -----
// Datapath: open interval, counters, entry table and the sequential scan.
module wlpt_datapath import wlpt_pkg::*; #(
  parameter int TABLE_ENTRIES = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IN_W-1:0]     in_bits,
  input  logic                cfg_down,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [OUT_W-1:0]    out_bits,
  output logic [1:0]          sync_state,
  input  logic [1:0]          sync_nxt,
  input  logic                sync_wr
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  in_item_t    it_r;
  entry_t      tbl_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [1:0]  sync_r;
  logic [31:0] open_time_r, open_addr_r, open_file_r;
  logic [15:0] open_line_r, open_proc_r, open_cause_r, open_mask_r;
  logic [31:0] floor_r, meas_r, unm_r;
  logic [IW-1:0] idx_r, pick_r, best_r;
  logic [31:0] lowest_r, max_r;
  logic        hit_r;
  logic [OUT_W-1:0] out_r;

  entry_t cur;
  logic [31:0] cur_lat, lat, cur_fin;
  logic [IW-1:0] pick;

  assign cur     = tbl_r[idx_r];
  assign cur_lat = vld_r[idx_r] ? cur.latency : 32'd0;
  assign cur_fin = vld_r[idx_r] ? cur.finish_address : 32'd0;
  assign lat     = cfg_down ? (open_time_r - it_r.timestamp) : (it_r.timestamp - open_time_r);
  assign pick    = hit_r ? idx_r : pick_r;

  assign stat.command     = it_r.command;
  assign stat.above_floor = (lat >= floor_r);
  assign stat.match_hit   = (it_r.site_address == cur_fin) &&
                            (open_addr_r == (vld_r[idx_r] ? cur.begin_address : 32'd0));
  assign stat.scan_last   = ({1'b0, idx_r} == (IW+1)'(TABLE_ENTRIES - 1));
  assign sync_state       = sync_r;
  assign out_bits         = out_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      sync_r <= SYNC_WAIT_START;
      open_time_r <= '0; open_addr_r <= '0; open_file_r <= '0;
      open_line_r <= '0; open_proc_r <= '0; open_cause_r <= '0; open_mask_r <= '0;
      floor_r <= '0; meas_r <= '0; unm_r <= '0;
    end else begin
      if (sync_wr) sync_r <= sync_nxt;
      if (cmd.cnt_unmatched) unm_r <= unm_r + 32'd1;
      if (cmd.do_clear) begin
        floor_r <= '0; meas_r <= '0; unm_r <= '0;
      end
      if (cmd.log_done) begin
        if (!hit_r) floor_r <= vld_r[pick_r] ? tbl_r[pick_r].latency : 32'd0;
        meas_r <= meas_r + 32'd1;
        if (lat > (vld_r[pick] ? tbl_r[pick].latency : 32'd0)) vld_r[pick] <= 1'b1;
      end
      if (cmd.read_done) vld_r[best_r] <= 1'b1;
      if (cmd.do_cause) begin
        if (it_r.cause_from == MASK_SELECTOR) open_mask_r <= open_mask_r | it_r.cause;
        else if (open_cause_r == it_r.cause_from) open_cause_r <= it_r.cause;
      end
      if (cmd.do_open) begin
        open_time_r  <= it_r.timestamp;
        open_addr_r  <= it_r.site_address;
        open_file_r  <= it_r.site_file;
        open_line_r  <= it_r.site_line;
        open_proc_r  <= it_r.process_id;
        open_cause_r <= it_r.cause;
        open_mask_r  <= '0;
      end
    end
  end

  // Table writes, scan registers, payload
  always_ff @(posedge clk) begin
    entry_t e;
    e = tbl_r[best_r];
    if (cmd.load) it_r <= in_bits[$bits(in_item_t)-1:0];
    if (cmd.scan_clr) begin
      idx_r <= '0; pick_r <= '0; best_r <= '0;
      lowest_r <= 32'hFFFF_FFFF; max_r <= '0; hit_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (lowest_r > cur_lat) begin
        lowest_r <= cur_lat;
        pick_r   <= idx_r;
      end
      if (cur_lat > max_r) begin
        max_r  <= cur_lat;
        best_r <= idx_r;
      end
      // a log scan halts on a match, a read scan always walks the table
      if (cmd.scan_hunt && stat.match_hit) hit_r <= 1'b1;
      else if (!stat.scan_last) idx_r <= idx_r + 1'b1;
    end
    if (cmd.log_done && (lat > (vld_r[pick] ? tbl_r[pick].latency : 32'd0))) begin
      tbl_r[pick] <= '{latency: lat, cause: open_cause_r, mask: open_mask_r,
                       begin_address: open_addr_r, begin_file: open_file_r,
                       begin_line: open_line_r, begin_process: open_proc_r,
                       finish_address: it_r.site_address, finish_file: it_r.site_file,
                       finish_line: it_r.site_line, finish_process: it_r.process_id};
    end
    if (cmd.read_done) begin
      if (!vld_r[best_r]) e = '0;
      out_r <= {meas_r, e.finish_process, e.finish_line, e.finish_file, e.finish_address,
                e.begin_process, e.begin_line, e.begin_file, e.begin_address,
                e.mask, e.cause, e.latency};
      e.latency = '0;
      e.finish_address = '0;
      tbl_r[best_r] <= e;
    end
  end

endmodule

// ----- rtl/wlpt_ctrl.sv -----
// Controller state machine sequencing events and table scans.
module wlpt_ctrl import wlpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_busy,
  input  logic      out_fire,
  input  logic      log_en,
  input  dp_stat_t  stat,
  input  logic [1:0] sync_state,
  output dp_cmd_t   cmd,
  output logic [1:0] sync_nxt,
  output logic      sync_wr,
  output logic      idle,
  output logic      out_set
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_LOG  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] st_r, st_nxt;
  logic       chk_r, chk_nxt;

  assign idle = (st_r == ST_IDLE);

  always_comb begin
    st_nxt = st_r; chk_nxt = chk_r;
    cmd = '0; sync_nxt = sync_state; sync_wr = 1'b0; out_set = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          st_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd.scan_clr = 1'b1;
        st_nxt = ST_IDLE;
        chk_nxt = 1'b0;
        case (stat.command)
          CMD_START: begin
            if (log_en && sync_state != SYNC_WAIT_END) begin
              cmd.do_open = 1'b1; sync_nxt = SYNC_WAIT_END; sync_wr = 1'b1;
            end
          end
          CMD_CHECK: begin
            if (log_en) begin
              if (sync_state != SYNC_WAIT_START && stat.above_floor) begin
                chk_nxt = 1'b1; st_nxt = ST_LOG;
              end else begin
                cmd.do_open = 1'b1; sync_nxt = SYNC_EITHER; sync_wr = 1'b1;
              end
            end
          end
          CMD_END: begin
            if (log_en) begin
              if (sync_state == SYNC_WAIT_START) cmd.cnt_unmatched = 1'b1;
              else begin
                sync_nxt = SYNC_WAIT_START; sync_wr = 1'b1;
                if (stat.above_floor) st_nxt = ST_LOG;
              end
            end
          end
          CMD_CAUSE: cmd.do_cause = 1'b1;
          CMD_READ:  st_nxt = ST_RD;
          CMD_CLEAR: begin
            cmd.do_clear = 1'b1; sync_nxt = SYNC_WAIT_START; sync_wr = 1'b1;
          end
          default: ;
        endcase
      end
      ST_LOG: begin
        cmd.scan_step = 1'b1;
        cmd.scan_hunt = 1'b1;
        if (stat.match_hit || stat.scan_last) st_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.log_done = 1'b1;
        st_nxt = ST_IDLE;
        if (chk_r) begin
          cmd.do_open = 1'b1; sync_nxt = SYNC_EITHER; sync_wr = 1'b1;
        end
      end
      ST_RD: begin
        if (!stat.scan_last) cmd.scan_step = 1'b1;
        else if (!out_busy || out_fire) begin
          cmd.scan_step = 1'b1;
        end
        if (stat.scan_last && (!out_busy || out_fire)) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // read result: best index settled
        cmd.read_done = 1'b1; out_set = 1'b1; st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; chk_r <= 1'b0;
    end else begin
      st_r <= st_nxt; chk_r <= chk_nxt;
    end
  end

endmodule

// ----- sim/tb_worst_latency_path_tracker.sv -----
// Testbench for the worst-latency path tracker: directed and random event streams.
`timescale 1ns / 100ps

module tb_worst_latency_path_tracker;
  import wlpt_pkg::*;

  localparam int ENTRIES = 20;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] CMD_SPARE = 3'd4;
  localparam logic [2:0] CMD_UNDEF = 3'd7;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;
  logic         cfg_we;
  logic         cfg_index;
  logic         cfg_wdata;

  worst_latency_path_tracker #(.TABLE_ENTRIES(ENTRIES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Result layout, highest field first
  typedef struct packed {
    logic [31:0] measured_total;
    logic [15:0] finish_process;
    logic [15:0] finish_line;
    logic [31:0] finish_file;
    logic [31:0] finish_address;
    logic [15:0] begin_process;
    logic [15:0] begin_line;
    logic [31:0] begin_file;
    logic [31:0] begin_address;
    logic [15:0] worst_mask;
    logic [15:0] worst_cause;
    logic [31:0] worst_latency;
  } report_t;

  // Tracker copy
  logic        log_en_q, count_down_q;
  logic [1:0]  sync_q;
  logic [31:0] open_time_q, open_addr_q, open_file_q;
  logic [15:0] open_line_q, open_proc_q, open_cause_q, open_mask_q;
  logic [31:0] floor_q, measured_q;
  entry_t      worst_tab [ENTRIES];
  report_t     pending_reports [$];

  int  error_count;
  int  idle_cycles;
  bit  gaps_on;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    error_count++;
  endtask

  function automatic void tracker_reset();
    log_en_q = 0; count_down_q = 0; sync_q = SYNC_WAIT_START;
    open_time_q = 0; open_addr_q = 0; open_file_q = 0; open_line_q = 0;
    open_proc_q = 0; open_cause_q = 0; open_mask_q = 0;
    floor_q = 0; measured_q = 0;
    for (int i = 0; i < ENTRIES; i++) worst_tab[i] = '0;
  endfunction

  function automatic void open_section(in_item_t it);
    open_time_q = it.timestamp; open_addr_q = it.site_address;
    open_file_q = it.site_file; open_line_q = it.site_line;
    open_proc_q = it.process_id; open_cause_q = it.cause; open_mask_q = 0;
  endfunction

  function automatic void record_interval(in_item_t it);
    logic [31:0] lat, lowest;
    int lowest_idx, pick;
    bit same;
    lat = count_down_q ? open_time_q - it.timestamp : it.timestamp - open_time_q;
    lowest = 32'hFFFFFFFF; lowest_idx = 0; same = 0; pick = 0;
    if (lat < floor_q) return;
    for (int i = 0; i < ENTRIES; i++) begin
      if (lowest > worst_tab[i].latency) begin
        lowest = worst_tab[i].latency; lowest_idx = i;
      end
      if (it.site_address == worst_tab[i].finish_address &&
          open_addr_q == worst_tab[i].begin_address) begin
        same = 1; pick = i; break;
      end
    end
    if (!same) begin
      pick = lowest_idx;
      floor_q = worst_tab[pick].latency;
    end
    if (lat > worst_tab[pick].latency) begin
      worst_tab[pick].latency = lat;
      worst_tab[pick].cause = open_cause_q;
      worst_tab[pick].mask = open_mask_q;
      worst_tab[pick].finish_address = it.site_address;
      worst_tab[pick].finish_file = it.site_file;
      worst_tab[pick].finish_line = it.site_line;
      worst_tab[pick].begin_address = open_addr_q;
      worst_tab[pick].begin_file = open_file_q;
      worst_tab[pick].begin_line = open_line_q;
      worst_tab[pick].begin_process = open_proc_q;
      worst_tab[pick].finish_process = it.process_id;
    end
    measured_q++;
  endfunction

  // Advance the tracker copy by one accepted beat
  function automatic void track_event(in_item_t it);
    int best;
    logic [31:0] top;
    report_t r;
    case (it.command)
      CMD_START:
        if (log_en_q && sync_q != SYNC_WAIT_END) begin
          open_section(it); sync_q = SYNC_WAIT_END;
        end
      CMD_CHECK:
        if (log_en_q) begin
          if (sync_q != SYNC_WAIT_START) record_interval(it);
          open_section(it); sync_q = SYNC_EITHER;
        end
      CMD_END:
        if (log_en_q && sync_q != SYNC_WAIT_START) begin
          record_interval(it); sync_q = SYNC_WAIT_START;
        end
      CMD_CAUSE:
        if (it.cause_from == MASK_SELECTOR) open_mask_q |= it.cause;
        else if (open_cause_q == it.cause_from) open_cause_q = it.cause;
      CMD_READ: begin
        best = 0; top = 0;
        for (int i = 0; i < ENTRIES; i++)
          if (worst_tab[i].latency > top) begin
            top = worst_tab[i].latency; best = i;
          end
        r.worst_latency = worst_tab[best].latency;
        r.worst_cause = worst_tab[best].cause;
        r.worst_mask = worst_tab[best].mask;
        r.begin_address = worst_tab[best].begin_address;
        r.begin_file = worst_tab[best].begin_file;
        r.begin_line = worst_tab[best].begin_line;
        r.begin_process = worst_tab[best].begin_process;
        r.finish_address = worst_tab[best].finish_address;
        r.finish_file = worst_tab[best].finish_file;
        r.finish_line = worst_tab[best].finish_line;
        r.finish_process = worst_tab[best].finish_process;
        r.measured_total = measured_q;
        pending_reports.push_back(r);
        worst_tab[best].latency = 0;
        worst_tab[best].finish_address = 0;
      end
      CMD_CLEAR: begin
        sync_q = SYNC_WAIT_START; floor_q = 0; measured_q = 0;
      end
      default: ;
    endcase
  endfunction

  // Send one beat, with an optional random gap before it
  task automatic send_event(input in_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk);
    in_tdata = {5'd0, it};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    track_event(it);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic in_item_t make_event(logic [2:0] cmd, logic [31:0] ts,
                                          logic [31:0] addr);
    in_item_t it;
    it.command = cmd; it.timestamp = ts; it.site_address = addr;
    it.site_file = $urandom; it.site_line = 16'($urandom); it.process_id = 16'($urandom);
    it.cause = 16'($urandom); it.cause_from = 16'($urandom);
    return it;
  endfunction

  // Wait for outstanding reports, then for a slow interval to finish
  task automatic drain();
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (3 * ENTRIES + 10) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_index = idx; cfg_wdata = val; cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_LOG_EN) log_en_q = val; else count_down_q = val;
  endtask

  // Result checker
  always @(posedge clk) begin
    report_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_reports.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        exp = pending_reports.pop_front();
        if (got.worst_latency !== exp.worst_latency)
          report_mismatch("worst_latency", got.worst_latency, exp.worst_latency);
        if (got.worst_cause !== exp.worst_cause)
          report_mismatch("worst_cause", 32'(got.worst_cause), 32'(exp.worst_cause));
        if (got.worst_mask !== exp.worst_mask)
          report_mismatch("worst_mask", 32'(got.worst_mask), 32'(exp.worst_mask));
        if (got.begin_address !== exp.begin_address)
          report_mismatch("begin_address", got.begin_address, exp.begin_address);
        if (got.begin_file !== exp.begin_file)
          report_mismatch("begin_file", got.begin_file, exp.begin_file);
        if (got.begin_line !== exp.begin_line)
          report_mismatch("begin_line", 32'(got.begin_line), 32'(exp.begin_line));
        if (got.begin_process !== exp.begin_process)
          report_mismatch("begin_process", 32'(got.begin_process),
                          32'(exp.begin_process));
        if (got.finish_address !== exp.finish_address)
          report_mismatch("finish_address", got.finish_address, exp.finish_address);
        if (got.finish_file !== exp.finish_file)
          report_mismatch("finish_file", got.finish_file, exp.finish_file);
        if (got.finish_line !== exp.finish_line)
          report_mismatch("finish_line", 32'(got.finish_line), 32'(exp.finish_line));
        if (got.finish_process !== exp.finish_process)
          report_mismatch("finish_process", 32'(got.finish_process),
                          32'(exp.finish_process));
        if (got.measured_total !== exp.measured_total)
          report_mismatch("measured_total", got.measured_total, exp.measured_total);
      end
    end
  end

  // Receiver stalls in bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Every command, some at the field extremes, both clock directions
  task automatic test_directed();
    in_item_t it;
    it = make_event(CMD_READ, 0, 0);
    send_event(it);                                  // read on an empty table
    it = make_event(CMD_START, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_event(it);                                  // ignored, logging off
    drain();
    write_reg(CFG_LOG_EN, 1'b1);
    it = make_event(CMD_END, 5, 1); send_event(it);  // end without start
    it = make_event(CMD_START, 32'hFFFFFFF0, 32'hFFFFFFFF);
    it.cause = 16'h8000; send_event(it);
    it = make_event(CMD_START, 0, 7); send_event(it); // start while open
    it = make_event(CMD_CAUSE, 0, 0);
    it.cause = 16'hFFFF; it.cause_from = MASK_SELECTOR; send_event(it);
    it = make_event(CMD_CAUSE, 0, 0);
    it.cause = 16'h7FFF; it.cause_from = 16'h8000; send_event(it);
    it = make_event(CMD_CHECK, 32'h10, 32'h0); send_event(it); // wraps
    it = make_event(CMD_END, 32'h20, 32'h0); send_event(it);
    it = make_event(CMD_SPARE, $urandom, $urandom); send_event(it);
    it = make_event(CMD_UNDEF, $urandom, $urandom); send_event(it);
    it = make_event(CMD_READ, 0, 0); send_event(it);
    it = make_event(CMD_READ, 0, 0); send_event(it);
    it = make_event(CMD_CLEAR, 0, 0); send_event(it);
    drain();
    write_reg(CFG_DOWN, 1'b1);
    it = make_event(CMD_START, 100, 32'h55); send_event(it);
    it = make_event(CMD_END, 40, 32'hAA); send_event(it);
    it = make_event(CMD_READ, 0, 0); send_event(it);
    drain();
    write_reg(CFG_DOWN, 1'b0);
  endtask

  // Mostly well-formed sections over a small address set
  task automatic test_random(input int count);
    in_item_t it;
    logic [31:0] now;
    int pick;
    now = $urandom;
    for (int n = 0; n < count; n++) begin
      now += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 500);
      pick = $urandom_range(0, 99);
      if (pick < 30) it = make_event(CMD_START, now, $urandom_range(0, 5));
      else if (pick < 45) it = make_event(CMD_CHECK, now, $urandom_range(0, 5));
      else if (pick < 72) it = make_event(CMD_END, now, $urandom_range(0, 5));
      else if (pick < 84) begin
        it = make_event(CMD_CAUSE, now, 0);
        if ($urandom_range(0, 1)) it.cause_from = MASK_SELECTOR;
        else if ($urandom_range(0, 1)) it.cause_from = open_cause_q;
      end
      else if (pick < 94) it = make_event(CMD_READ, now, 0);
      else if (pick < 96) it = make_event(CMD_CLEAR, now, 0);
      else begin
        it = make_event(3'($urandom_range(0, 7)), $urandom, $urandom);
      end
      send_event(it);
    end
  endtask

  initial begin
    error_count = 0; idle_cycles = 0; gaps_on = 1;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = 1'b0;
    tracker_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(700);
    drain();                                         // sender waits for all results
    write_reg(CFG_DOWN, 1'b1);
    test_random(600);
    drain();
    write_reg(CFG_LOG_EN, 1'b0);
    test_random(100);
    drain();
    write_reg(CFG_LOG_EN, 1'b1);
    write_reg(CFG_DOWN, 1'b0);
    gaps_on = 0;
    test_random(600);
    drain();

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
